// ===== rtl/move_to_front_encoder_top_defines.svh =====
// Assertion macros for the move-to-front encoder.
// Included by move_to_front_encoder_top; expects clk_i and rst_ni in scope.
`ifndef MOVE_TO_FRONT_ENCODER_TOP_DEFINES_SVH
`define MOVE_TO_FRONT_ENCODER_TOP_DEFINES_SVH

// Same-cycle implication, checked at every rising edge out of reset
`define MTFE_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("mtfe: same-cycle check failed");

// Next-cycle implication, checked at every rising edge out of reset
`define MTFE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("mtfe: next-cycle check failed");

`endif

// ===== rtl/mtfe_pkg.sv =====
// Shared constants, types and the initial list order for the move-to-front encoder.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package mtfe_pkg;

  // Number of entries in the symbol list (2..64)
  localparam int LIST_SIZE = 64;
  localparam int IDX_W     = (LIST_SIZE > 1) ? $clog2(LIST_SIZE) : 1;
  localparam int SYM_W     = 8;
  localparam int RANK_W    = 6;
  localparam int ALPHA_LEN = 63;
  localparam int PUNCT_LEN = 10;

  // Punctuation tail of the alphabet: ( ) ' : , . ! ? ' "
  localparam logic [SYM_W-1:0] PUNCT_TAB [PUNCT_LEN] = '{
    8'h28, 8'h29, 8'h27, 8'h3a, 8'h2c, 8'h2e, 8'h21, 8'h3f, 8'h27, 8'h22
  };

  // Control broadcast from the sequencer to every cell
  typedef struct packed {
    logic             restore;  // reload initial order
    logic             compare;  // capture entry == symbol
    logic             commit;   // shift toward the hit and insert symbol
    logic [SYM_W-1:0] symbol;
  } mtfe_ctrl_t;

  // Initial content of list entry idx: alphabet, then terminator bytes
  function automatic logic [SYM_W-1:0] init_entry(input int idx);
    logic [SYM_W-1:0] val;
    val = '0;
    if ((idx < ALPHA_LEN) && (idx + 1 < LIST_SIZE)) begin
      if (idx < 26) begin
        val = 8'h61 + SYM_W'(idx);
      end else if (idx == 26) begin
        val = 8'h20;
      end else if (idx < 53) begin
        val = 8'h41 + SYM_W'(idx - 27);
      end else begin
        val = PUNCT_TAB[4'(idx - 53)];
      end
    end
    return val;
  endfunction

endpackage

// ===== rtl/mtfe_cell.sv =====
// One list entry of the move-to-front encoder: holds a byte, compares it,
// and takes its neighbor's byte on a move. Depends on mtfe_pkg.
`timescale 1ns / 1ps

module mtfe_cell (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  mtfe_pkg::mtfe_ctrl_t            ctrl_i,
  input  logic [mtfe_pkg::SYM_W-1:0]      init_i,   // reset / block-start value
  input  logic [mtfe_pkg::SYM_W-1:0]      prev_i,   // entry of the cell in front
  input  logic                            found_i,  // a cell in front matched
  output logic                            found_o,
  output logic                            first_o,  // this cell is the first match
  output logic [mtfe_pkg::SYM_W-1:0]      entry_o
);

  logic [mtfe_pkg::SYM_W-1:0] entry_q;
  logic                       match_q;

  // Stored entry: reload, or take the neighbor's byte when the hit is at or behind us
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= init_i;
    end else if (ctrl_i.restore) begin
      entry_q <= init_i;
    end else if (ctrl_i.commit && !found_i) begin
      entry_q <= prev_i;
    end
  end

  // Registered compare against the item's symbol
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
    end else if (ctrl_i.compare) begin
      match_q <= (entry_q == ctrl_i.symbol);
    end
  end

  assign found_o = found_i | match_q;
  assign first_o = match_q & ~found_i;
  assign entry_o = entry_q;

endmodule

// ===== rtl/mtfe_rank_enc.sv =====
// Encodes the one-hot first-match vector of the cell row into a position.
// Depends on mtfe_pkg.
`timescale 1ns / 1ps

module mtfe_rank_enc (
  input  logic [mtfe_pkg::LIST_SIZE-1:0] first_i,
  output logic [mtfe_pkg::IDX_W-1:0]     idx_o
);

  // OR of the indices of set bits; at most one bit is set
  always_comb begin
    idx_o = '0;
    for (int i = 0; i < mtfe_pkg::LIST_SIZE; i++) begin
      if (first_i[i]) begin
        idx_o = idx_o | mtfe_pkg::IDX_W'(i);
      end
    end
  end

endmodule

// ===== rtl/move_to_front_encoder_top.sv =====
// Move-to-front encoder: a row of 64 byte cells holds the symbol list. Each item
// goes through the accept edge (block_start reloads the initial order here),
// a compare cycle in which every cell registers entry == symbol, and a resolve
// cycle in which the first-match flag ripples down the row, the rank is
// encoded and the cells ahead of the hit shift back one place. in_stall_o is
// high from acceptance until resolve; on a hit, resolve waits while a previous
// rank is still stalled in the output register. A symbol not in the list gives
// no rank. Depends on mtfe_pkg, mtfe_cell, mtfe_rank_enc and the defines header.
`timescale 1ns / 1ps
`include "move_to_front_encoder_top_defines.svh"

module move_to_front_encoder_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [mtfe_pkg::SYM_W-1:0]   symbol_i,
  input  logic                         block_start_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [mtfe_pkg::RANK_W-1:0]  rank_o
);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_CMP  = 2'd1;
  localparam logic [1:0] PH_RES  = 2'd2;

  logic [1:0]                   phase_q, phase_d;
  logic [mtfe_pkg::SYM_W-1:0]   sym_q;
  logic                         out_valid_q, out_valid_d;
  logic [mtfe_pkg::RANK_W-1:0]  rank_q;
  logic                         in_acc;
  logic                         out_free;
  logic                         hit;
  logic                         done;
  mtfe_pkg::mtfe_ctrl_t         ctrl;

  logic [mtfe_pkg::SYM_W-1:0]   entry_w [mtfe_pkg::LIST_SIZE];
  logic [mtfe_pkg::LIST_SIZE:0] found_w;
  logic [mtfe_pkg::LIST_SIZE-1:0] first_w;
  logic [mtfe_pkg::IDX_W-1:0]   idx_w;

  assign in_acc   = in_valid_i && (phase_q == PH_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;
  assign hit      = found_w[mtfe_pkg::LIST_SIZE];
  // resolve completes when there is no result or the output can take it
  assign done     = (phase_q == PH_RES) && (!hit || out_free);

  // Sequencer
  always_comb begin
    phase_d = phase_q;
    unique case (phase_q)
      PH_IDLE: if (in_acc) phase_d = PH_CMP;
      PH_CMP:  phase_d = PH_RES;
      PH_RES:  if (done) phase_d = PH_IDLE;
      default: phase_d = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
    end else begin
      phase_q <= phase_d;
    end
  end

  // Item symbol
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      sym_q <= symbol_i;
    end
  end

  // Cell control
  always_comb begin
    ctrl.restore = in_acc && block_start_i;
    ctrl.compare = (phase_q == PH_CMP);
    ctrl.commit  = done && hit;
    ctrl.symbol  = sym_q;
  end

  // Cell row; the front cell takes the symbol itself
  assign found_w[0] = 1'b0;

  for (genvar g = 0; g < mtfe_pkg::LIST_SIZE; g++) begin : g_cell
    logic [mtfe_pkg::SYM_W-1:0] prev_w;
    if (g == 0) begin : g_front
      assign prev_w = sym_q;
    end else begin : g_rest
      assign prev_w = entry_w[g-1];
    end

    mtfe_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .init_i  (mtfe_pkg::init_entry(g)),
      .prev_i  (prev_w),
      .found_i (found_w[g]),
      .found_o (found_w[g+1]),
      .first_o (first_w[g]),
      .entry_o (entry_w[g])
    );
  end

  mtfe_rank_enc u_rank_enc (
    .first_i (first_w),
    .idx_o   (idx_w)
  );

  // Output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (ctrl.commit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.commit) begin
      rank_q <= mtfe_pkg::RANK_W'(idx_w);
    end
  end

  assign in_stall_o  = (phase_q != PH_IDLE);
  assign out_valid_o = out_valid_q;
  assign rank_o      = rank_q;

  // Checks
  `MTFE_ASSERT_NOW(a_first_onehot, 1'b1, $onehot0(first_w))
  `MTFE_ASSERT_NOW(a_out_from_res, $rose(out_valid_o), $past(phase_q) == PH_RES)
  `MTFE_ASSERT_NEXT(a_acc_to_cmp, in_valid_i && !in_stall_o, phase_q == PH_CMP)

endmodule
